// File: hw/rtl/sfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared widths, codes and the sequencer microcode for the smallest-factor
// sieve core.
// ----------------------------------------------------------------------------
package sfs_pkg;

  // field widths
  localparam int VAL_W  = 13;
  localparam int IDX_W  = 12;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  // walking counters reach one past the largest table size
  localparam int CNT_W  = VAL_W + 1;
  localparam int SUM_W  = CNT_W + 1;

  localparam int              MAX_N_DEF = 4096;
  localparam logic [VAL_W-1:0] LIMIT_RST = 13'd4096;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_BUILD       = 2'd0,
    CMD_READ_FACTOR = 2'd1,
    CMD_READ_PRIME  = 2'd2,
    CMD_UNUSED      = 2'd3
  } cmd_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NOT_BUILT = 2'd2
  } status_e;

  // sequencer step addresses
  typedef enum logic [3:0] {
    S_IDLE     = 4'd0,
    S_INIT_CHK = 4'd1,
    S_INIT_WR  = 4'd2,
    S_D_START  = 4'd3,
    S_D_CHK    = 4'd4,
    S_D_TEST   = 4'd5,
    S_J_RD     = 4'd6,
    S_J_WR     = 4'd7,
    S_D_NEXT   = 4'd8,
    S_C_START  = 4'd9,
    S_C_CHK    = 4'd10,
    S_C_TEST   = 4'd11,
    S_FIN      = 4'd12,
    S_RESP     = 4'd13,
    S_RD       = 4'd14
  } step_e;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_DISPATCH,
    C_K_GT_N,
    C_K_LT_N,
    C_RD_NE_1,
    C_J_NEXT_LE_N,
    C_OUT_FREE
  } cond_e;

  // main counter operation
  typedef enum logic [1:0] {
    K_HOLD,
    K_ONE,
    K_TWO,
    K_INC
  } kop_e;

  // multiple walker operation
  typedef enum logic [1:0] {
    J_HOLD,
    J_LOAD,
    J_STEP
  } jop_e;

  // factor table read address select
  typedef enum logic [1:0] {
    FR_NONE,
    FR_K,
    FR_J,
    FR_IDX
  } frd_e;

  // factor table write select
  typedef enum logic [1:0] {
    FW_NONE,
    FW_ONE_K,
    FW_MARK_J
  } fwr_e;

  // one control word
  typedef struct packed {
    cond_e cond;
    step_e target;
    logic  hold;
    kop_e  k_op;
    jop_e  j_op;
    frd_e  fac_rd;
    fwr_e  fac_wr;
    logic  pl_rd;
    logic  pl_wr;
    logic  tot_clr;
    logic  set_built;
    logic  res_ld;
  } uword_t;

  // microcode rom
  function automatic uword_t ucode(step_e step);
    uword_t w;
    w = '{cond: C_NEVER, target: S_IDLE, hold: 1'b0, k_op: K_HOLD, j_op: J_HOLD,
          fac_rd: FR_NONE, fac_wr: FW_NONE, pl_rd: 1'b0, pl_wr: 1'b0,
          tot_clr: 1'b0, set_built: 1'b0, res_ld: 1'b0};
    case (step)
      S_IDLE: begin
        w.k_op = K_ONE;
        w.hold = 1'b1;
        w.cond = C_DISPATCH;
      end
      S_INIT_CHK: begin
        w.cond   = C_K_GT_N;
        w.target = S_D_START;
      end
      S_INIT_WR: begin
        w.fac_wr = FW_ONE_K;
        w.k_op   = K_INC;
        w.cond   = C_K_LT_N;
        w.target = S_INIT_WR;
      end
      S_D_START: begin
        w.k_op = K_TWO;
      end
      S_D_CHK: begin
        w.fac_rd = FR_K;
        w.cond   = C_K_GT_N;
        w.target = S_C_START;
      end
      S_D_TEST: begin
        w.j_op   = J_LOAD;
        w.cond   = C_RD_NE_1;
        w.target = S_D_NEXT;
      end
      S_J_RD: begin
        w.fac_rd = FR_J;
      end
      S_J_WR: begin
        w.fac_wr = FW_MARK_J;
        w.j_op   = J_STEP;
        w.cond   = C_J_NEXT_LE_N;
        w.target = S_J_RD;
      end
      S_D_NEXT: begin
        w.k_op   = K_INC;
        w.cond   = C_ALWAYS;
        w.target = S_D_CHK;
      end
      S_C_START: begin
        w.k_op    = K_ONE;
        w.tot_clr = 1'b1;
      end
      S_C_CHK: begin
        w.fac_rd = FR_K;
        w.cond   = C_K_GT_N;
        w.target = S_FIN;
      end
      S_C_TEST: begin
        w.pl_wr  = 1'b1;
        w.k_op   = K_INC;
        w.cond   = C_ALWAYS;
        w.target = S_C_CHK;
      end
      S_FIN: begin
        w.set_built = 1'b1;
      end
      S_RESP: begin
        w.res_ld = 1'b1;
        w.hold   = 1'b1;
        w.cond   = C_OUT_FREE;
        w.target = S_IDLE;
      end
      S_RD: begin
        w.fac_rd = FR_IDX;
        w.pl_rd  = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = S_RESP;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/sfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module sfs_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/smallest_factor_sieve_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smallest_factor_sieve_core
// Sieve engine: builds a smallest-factor table over 1..n, compacts the
// entries that equal their own natural into a rank list, and serves reads.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ---------------------------------
//  input    in         in_valid_i / in_stall_o   cmd_i, index_i
//  output   out        out_valid_o / out_stall_i value_o, prime_count_o, status_o
//  config   in         cfg_we_i                  cfg_wdata_i (limit)
//
//  A read passes through the read step, which reads both tables, and the
//  response step, which loads the result register; an unused command goes
//  straight to the response step. The next command is taken back in idle.
//  In a build each marking visit reads an entry and writes it if unmarked.
//  Reset leaves the table unbuilt; no memory clearing pass is needed.
//  One item at a time; a finished item waits for the output register to free
//  under out_stall_i, and the next is taken while that result still waits.
//
module smallest_factor_sieve_core #(
  parameter int MAX_N = sfs_pkg::MAX_N_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [sfs_pkg::VAL_W-1:0]   cfg_wdata_i,
  // command channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sfs_pkg::CMD_W-1:0]   cmd_i,
  input  logic [sfs_pkg::IDX_W-1:0]   index_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sfs_pkg::VAL_W-1:0]   value_o,
  output logic [sfs_pkg::VAL_W-1:0]   prime_count_o,
  output logic [sfs_pkg::STAT_W-1:0]  status_o
);

  localparam int AW = $clog2(MAX_N);

  // sequencer
  sfs_pkg::step_e  upc_q, upc_d;
  sfs_pkg::uword_t uw;
  sfs_pkg::step_e  dispatch_tgt;
  logic            cond_true;

  // datapath registers
  logic [sfs_pkg::VAL_W-1:0] limit_q;
  logic [sfs_pkg::VAL_W-1:0] n_q, n_d;
  logic [sfs_pkg::VAL_W-1:0] total_q, total_d;
  logic                      built_q, built_d;
  logic [sfs_pkg::CNT_W-1:0] k_q, k_d;
  logic [sfs_pkg::CNT_W-1:0] j_q, j_d;
  sfs_pkg::cmd_e             cmd_q;
  logic [sfs_pkg::IDX_W-1:0] idx_q;

  // result register
  logic                       out_valid_q, out_valid_d;
  logic [sfs_pkg::VAL_W-1:0]  value_q, value_d;
  logic [sfs_pkg::VAL_W-1:0]  count_q;
  sfs_pkg::status_e           status_q, status_d;

  // memory ports
  logic                      fac_we, fac_re, pl_we;
  logic [AW-1:0]             fac_waddr, fac_raddr, pl_waddr, pl_raddr;
  logic [sfs_pkg::VAL_W-1:0] fac_wdata, fac_rdata, pl_rdata;

  logic                      in_accept;
  logic                      out_free;
  logic                      res_load;
  logic                      rd_is_one;
  logic                      rd_is_k;
  logic [sfs_pkg::VAL_W-1:0] n_clamp;
  logic [sfs_pkg::SUM_W-1:0] j_next;

  assign uw        = sfs_pkg::ucode(upc_q);
  assign in_stall_o = (upc_q != sfs_pkg::S_IDLE);
  assign in_accept = in_valid_i && (upc_q == sfs_pkg::S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign res_load  = uw.res_ld && out_free;

  assign rd_is_one = (fac_rdata == sfs_pkg::VAL_W'(1));
  assign rd_is_k   = (fac_rdata == sfs_pkg::VAL_W'(k_q));
  assign j_next    = sfs_pkg::SUM_W'(j_q) + sfs_pkg::SUM_W'(k_q);
  assign n_clamp   = (32'(limit_q) > MAX_N) ? sfs_pkg::VAL_W'(MAX_N) : limit_q;

  // command dispatch target
  always_comb begin
    case (sfs_pkg::cmd_e'(cmd_i))
      sfs_pkg::CMD_BUILD:       dispatch_tgt = sfs_pkg::S_INIT_CHK;
      sfs_pkg::CMD_READ_FACTOR: dispatch_tgt = sfs_pkg::S_RD;
      sfs_pkg::CMD_READ_PRIME:  dispatch_tgt = sfs_pkg::S_RD;
      default:                  dispatch_tgt = sfs_pkg::S_RESP;
    endcase
  end

  // jump condition
  always_comb begin
    case (uw.cond)
      sfs_pkg::C_ALWAYS:      cond_true = 1'b1;
      sfs_pkg::C_DISPATCH:    cond_true = in_valid_i;
      sfs_pkg::C_K_GT_N:      cond_true = (k_q > sfs_pkg::CNT_W'(n_q));
      sfs_pkg::C_K_LT_N:      cond_true = (k_q < sfs_pkg::CNT_W'(n_q));
      sfs_pkg::C_RD_NE_1:     cond_true = !rd_is_one;
      sfs_pkg::C_J_NEXT_LE_N: cond_true = (j_next <= sfs_pkg::SUM_W'(n_q));
      sfs_pkg::C_OUT_FREE:    cond_true = out_free;
      default:                cond_true = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (cond_true) begin
      upc_d = (uw.cond == sfs_pkg::C_DISPATCH) ? dispatch_tgt : uw.target;
    end else if (uw.hold) begin
      upc_d = upc_q;
    end else begin
      upc_d = sfs_pkg::step_e'(4'(upc_q + 4'd1));
    end
  end

  // counters and build state
  always_comb begin
    k_d     = k_q;
    j_d     = j_q;
    n_d     = n_q;
    total_d = total_q;
    built_d = built_q;
    case (uw.k_op)
      sfs_pkg::K_ONE: k_d = sfs_pkg::CNT_W'(1);
      sfs_pkg::K_TWO: k_d = sfs_pkg::CNT_W'(2);
      sfs_pkg::K_INC: k_d = k_q + sfs_pkg::CNT_W'(1);
      default:        k_d = k_q;
    endcase
    case (uw.j_op)
      sfs_pkg::J_LOAD: j_d = k_q;
      sfs_pkg::J_STEP: j_d = sfs_pkg::CNT_W'(j_next);
      default:         j_d = j_q;
    endcase
    if (in_accept && (sfs_pkg::cmd_e'(cmd_i) == sfs_pkg::CMD_BUILD)) begin
      n_d = n_clamp;
    end
    if (uw.tot_clr) begin
      total_d = '0;
    end else if (pl_we) begin
      total_d = total_q + sfs_pkg::VAL_W'(1);
    end
    if (uw.set_built) begin
      built_d = 1'b1;
    end
  end

  // factor table port control
  always_comb begin
    fac_re    = (uw.fac_rd != sfs_pkg::FR_NONE);
    case (uw.fac_rd)
      sfs_pkg::FR_J:   fac_raddr = AW'(j_q - sfs_pkg::CNT_W'(1));
      sfs_pkg::FR_IDX: fac_raddr = AW'(idx_q);
      default:         fac_raddr = AW'(k_q - sfs_pkg::CNT_W'(1));
    endcase
    case (uw.fac_wr)
      sfs_pkg::FW_ONE_K: begin
        fac_we    = 1'b1;
        fac_waddr = AW'(k_q - sfs_pkg::CNT_W'(1));
        fac_wdata = sfs_pkg::VAL_W'(1);
      end
      sfs_pkg::FW_MARK_J: begin
        fac_we    = rd_is_one;
        fac_waddr = AW'(j_q - sfs_pkg::CNT_W'(1));
        fac_wdata = sfs_pkg::VAL_W'(k_q);
      end
      default: begin
        fac_we    = 1'b0;
        fac_waddr = AW'(k_q - sfs_pkg::CNT_W'(1));
        fac_wdata = sfs_pkg::VAL_W'(k_q);
      end
    endcase
  end

  // rank list port control
  assign pl_we    = uw.pl_wr && rd_is_k;
  assign pl_waddr = AW'(total_q);
  assign pl_raddr = AW'(idx_q);

  // result value and status
  always_comb begin
    value_d  = '0;
    status_d = sfs_pkg::ST_OK;
    case (cmd_q)
      sfs_pkg::CMD_BUILD: begin
        status_d = sfs_pkg::ST_OK;
      end
      sfs_pkg::CMD_READ_FACTOR: begin
        if (!built_q) begin
          status_d = sfs_pkg::ST_NOT_BUILT;
        end else if (sfs_pkg::VAL_W'(idx_q) < n_q) begin
          value_d = fac_rdata;
        end else begin
          status_d = sfs_pkg::ST_RANGE;
        end
      end
      sfs_pkg::CMD_READ_PRIME: begin
        if (!built_q) begin
          status_d = sfs_pkg::ST_NOT_BUILT;
        end else if (sfs_pkg::VAL_W'(idx_q) < total_q) begin
          value_d = pl_rdata;
        end else begin
          status_d = sfs_pkg::ST_RANGE;
        end
      end
      default: begin
        status_d = sfs_pkg::ST_RANGE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    if (res_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= sfs_pkg::S_IDLE;
      limit_q     <= sfs_pkg::LIMIT_RST;
      n_q         <= '0;
      total_q     <= '0;
      built_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      n_q         <= n_d;
      total_q     <= total_d;
      built_q     <= built_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    j_q <= j_d;
    if (in_accept) begin
      cmd_q <= sfs_pkg::cmd_e'(cmd_i);
      idx_q <= index_i;
    end
    if (res_load) begin
      value_q  <= value_d;
      count_q  <= total_q;
      status_q <= status_d;
    end
  end

  // factor table
  sfs_ram #(
    .WIDTH (sfs_pkg::VAL_W),
    .DEPTH (MAX_N)
  ) u_fac_ram (
    .clk_i   (clk_i),
    .we_i    (fac_we),
    .waddr_i (fac_waddr),
    .wdata_i (fac_wdata),
    .re_i    (fac_re),
    .raddr_i (fac_raddr),
    .rdata_o (fac_rdata)
  );

  // rank list
  sfs_ram #(
    .WIDTH (sfs_pkg::VAL_W),
    .DEPTH (MAX_N)
  ) u_pl_ram (
    .clk_i   (clk_i),
    .we_i    (pl_we),
    .waddr_i (pl_waddr),
    .wdata_i (sfs_pkg::VAL_W'(k_q)),
    .re_i    (uw.pl_rd),
    .raddr_i (pl_raddr),
    .rdata_o (pl_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign value_o       = value_q;
  assign prime_count_o = count_q;
  assign status_o      = status_q;

`ifndef ASSERT_OFF
  // a new result only comes from the response step
  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(upc_q) == sfs_pkg::S_RESP)
    else $error("result loaded outside response step");

  // list never outgrows the table between commands
  a_total_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q == sfs_pkg::S_IDLE |-> total_q <= n_q)
    else $error("prime count exceeds table size");

  // marking walker stays within the table and not below its divisor
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q == sfs_pkg::S_J_WR |-> (j_q <= sfs_pkg::CNT_W'(n_q)) && (j_q >= k_q))
    else $error("multiple walker out of range");

  // divisor under test is a real candidate
  a_divisor_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q == sfs_pkg::S_D_TEST |->
      (k_q >= sfs_pkg::CNT_W'(2)) && (k_q <= sfs_pkg::CNT_W'(n_q)))
    else $error("divisor out of range");

  // the table is marked built only at the end of a build
  a_built_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(built_q) |-> $past(upc_q) == sfs_pkg::S_FIN && $past(cmd_q) == sfs_pkg::CMD_BUILD)
    else $error("built flag set outside a build");
`endif

endmodule
